// ----- src/bfpe_pkg.sv -----
// Shared item and result types, mode codes, instruction characters and status codes.
package bfpe_pkg;

  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_RESTART = 2'd1;
  localparam logic [1:0] MODE_EXEC    = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [1:0] STATUS_UNDERRUN = 2'd2;

  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_INC   = 8'h2B;
  localparam logic [7:0] CH_DEC   = 8'h2D;
  localparam logic [7:0] CH_IN    = 8'h2C;
  localparam logic [7:0] CH_OUT   = 8'h2E;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  localparam int LEN_W = 13;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] prog_addr;
    logic [7:0]  prog_byte;
    logic [7:0]  in_byte;
  } item_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       in_taken;
    logic       halted;
    logic [1:0] status;
  } result_t;

endpackage

// ----- src/bfpe_ram.sv -----
// Single-port synchronous RAM with registered read data.
module bfpe_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/bf_program_executor.sv -----
// Byte-tape program executor: program, tape and loop stack RAMs with a sequencing FSM.
//
// Items enter on item_i when start_i is high and busy_o is low. Mode write stores one
// program byte, mode restart clears the tape and run state, mode execute runs one
// instruction at the program counter. Every item gives exactly one result beat on res_o,
// marked by res_valid_o for a single cycle; the receiver cannot stall it.
// An execute item reads program and tape, then decodes and writes back in S_DECODE;
// its result appears in the cycle after. A skipped '[' walks program memory one byte
// at a time via S_SKIP_RD and S_SKIP_CHK until its matching ']' or the program end.
// A write item subtracts PROG_DEPTH from its address in S_REDUCE until it is in range,
// then writes. A restart sweeps every tape cell, then gives its result. After reset the
// same sweep runs with busy_o high and no result. The user must write program_length
// through cfg_we_i/cfg_data_i only while idle; the block itself does not enforce it.
module bf_program_executor #(
  parameter int TAPE_CELLS  = 1024,
  parameter int PROG_DEPTH  = 4096,
  parameter int STACK_DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  bfpe_pkg::item_t            item_i,
  output logic                       res_valid_o,
  output bfpe_pkg::result_t          res_o,
  input  logic                       cfg_we_i,
  input  logic [bfpe_pkg::LEN_W-1:0] cfg_data_i
);

  import bfpe_pkg::*;

  localparam int CPW = $clog2(TAPE_CELLS);
  localparam int PAW = $clog2(PROG_DEPTH);
  localparam int PCW = $clog2(PROG_DEPTH + 2);
  localparam int SW  = $clog2(STACK_DEPTH);
  localparam int LVW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_REDUCE, S_DECODE, S_SKIP_RD, S_SKIP_CHK
  } state_e;

  state_e           state_q;
  logic [PCW-1:0]   pc_q;
  logic [CPW-1:0]   cp_q;
  logic [LVW-1:0]   lvl_q;
  logic [1:0]       err_q;
  logic [LEN_W-1:0] len_q;
  logic [11:0]      addr_q;
  logic [7:0]       pbyte_q;
  logic [7:0]       inb_q;
  logic [PCW-1:0]   skip_a_q;
  logic [PCW-1:0]   depth_q;
  logic [CPW-1:0]   clr_q;
  logic             clr_rep_q;
  logic             res_valid_q;
  logic             ov_q;
  logic [7:0]       ob_q;
  logic             tk_q;

  logic [PCW-1:0]   end_w;
  logic             halted_w;

  logic             prog_we;
  logic [PAW-1:0]   prog_addr;
  logic [7:0]       prog_rdata;
  logic             tape_we;
  logic [CPW-1:0]   tape_addr;
  logic [7:0]       tape_wdata;
  logic [7:0]       tape_rdata;
  logic             stk_we;
  logic [SW-1:0]    stk_addr;
  logic [PAW-1:0]   stk_rdata;

  assign end_w    = (32'(len_q) < PROG_DEPTH) ? PCW'(len_q) : PCW'(PROG_DEPTH);
  assign halted_w = (err_q != STATUS_OK) || (pc_q >= end_w);

  bfpe_ram #(.DEPTH(PROG_DEPTH), .WIDTH(8)) u_prog (
    .clk_i   (clk_i),
    .we_i    (prog_we),
    .addr_i  (prog_addr),
    .wdata_i (pbyte_q),
    .rdata_o (prog_rdata)
  );

  bfpe_ram #(.DEPTH(TAPE_CELLS), .WIDTH(8)) u_tape (
    .clk_i   (clk_i),
    .we_i    (tape_we),
    .addr_i  (tape_addr),
    .wdata_i (tape_wdata),
    .rdata_o (tape_rdata)
  );

  bfpe_ram #(.DEPTH(STACK_DEPTH), .WIDTH(PAW)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .addr_i  (stk_addr),
    .wdata_i (PAW'(pc_q)),
    .rdata_o (stk_rdata)
  );

  always_comb begin
    prog_we    = 1'b0;
    prog_addr  = PAW'(pc_q);
    tape_we    = 1'b0;
    tape_addr  = cp_q;
    tape_wdata = 8'd0;
    stk_we     = 1'b0;
    stk_addr   = SW'(lvl_q - LVW'(1));
    case (state_q)
      S_CLEAR: begin
        tape_we   = 1'b1;
        tape_addr = clr_q;
      end
      S_REDUCE: begin
        prog_addr = PAW'(addr_q);
        prog_we   = (32'(addr_q) < PROG_DEPTH);
      end
      S_SKIP_RD: begin
        prog_addr = PAW'(skip_a_q);
      end
      S_DECODE: begin
        case (prog_rdata)
          CH_INC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata + 8'd1;
          end
          CH_DEC: begin
            tape_we    = (tape_rdata != 8'd0);
            tape_wdata = tape_rdata - 8'd1;
          end
          CH_IN: begin
            tape_we    = 1'b1;
            tape_wdata = inb_q;
          end
          CH_OPEN: begin
            stk_addr = SW'(lvl_q);
            stk_we   = (tape_rdata != 8'd0) && (32'(lvl_q) < STACK_DEPTH);
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      pc_q        <= '0;
      cp_q        <= '0;
      lvl_q       <= '0;
      err_q       <= STATUS_OK;
      len_q       <= '0;
      addr_q      <= '0;
      pbyte_q     <= '0;
      inb_q       <= '0;
      skip_a_q    <= '0;
      depth_q     <= '0;
      clr_q       <= '0;
      clr_rep_q   <= 1'b0;
      res_valid_q <= 1'b0;
      ov_q        <= 1'b0;
      ob_q        <= '0;
      tk_q        <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_we_i) begin
        len_q <= cfg_data_i;
      end
      case (state_q)
        S_CLEAR: begin
          if (clr_q == CPW'(TAPE_CELLS - 1)) begin
            pc_q        <= '0;
            cp_q        <= '0;
            lvl_q       <= '0;
            err_q       <= STATUS_OK;
            res_valid_q <= clr_rep_q;
            ov_q        <= 1'b0;
            ob_q        <= '0;
            tk_q        <= 1'b0;
            state_q     <= S_IDLE;
          end else begin
            clr_q <= clr_q + CPW'(1);
          end
        end
        S_IDLE: begin
          if (start_i) begin
            ov_q  <= 1'b0;
            ob_q  <= '0;
            tk_q  <= 1'b0;
            inb_q <= item_i.in_byte;
            case (item_i.mode)
              MODE_WRITE: begin
                addr_q  <= item_i.prog_addr;
                pbyte_q <= item_i.prog_byte;
                state_q <= S_REDUCE;
              end
              MODE_RESTART: begin
                clr_q     <= '0;
                clr_rep_q <= 1'b1;
                state_q   <= S_CLEAR;
              end
              MODE_EXEC: begin
                if (halted_w) begin
                  res_valid_q <= 1'b1;
                end else begin
                  state_q <= S_DECODE;
                end
              end
              default: begin
                res_valid_q <= 1'b1;
              end
            endcase
          end
        end
        S_REDUCE: begin
          if (32'(addr_q) >= PROG_DEPTH) begin
            addr_q <= addr_q - 12'(PROG_DEPTH);
          end else begin
            res_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_DECODE: begin
          res_valid_q <= 1'b1;
          state_q     <= S_IDLE;
          pc_q        <= pc_q + PCW'(1);
          case (prog_rdata)
            CH_RIGHT: begin
              if (cp_q != CPW'(TAPE_CELLS - 1)) begin
                cp_q <= cp_q + CPW'(1);
              end
            end
            CH_LEFT: begin
              if (cp_q != '0) begin
                cp_q <= cp_q - CPW'(1);
              end
            end
            CH_IN: begin
              tk_q <= 1'b1;
            end
            CH_OUT: begin
              ov_q <= 1'b1;
              ob_q <= tape_rdata;
            end
            CH_OPEN: begin
              if (tape_rdata == 8'd0) begin
                skip_a_q    <= pc_q + PCW'(1);
                depth_q     <= '0;
                res_valid_q <= 1'b0;
                pc_q        <= pc_q;
                state_q     <= S_SKIP_RD;
              end else if (32'(lvl_q) >= STACK_DEPTH) begin
                err_q <= STATUS_OVERFLOW;
                pc_q  <= pc_q;
              end else begin
                lvl_q <= lvl_q + LVW'(1);
              end
            end
            CH_CLOSE: begin
              if (lvl_q == '0) begin
                err_q <= STATUS_UNDERRUN;
                pc_q  <= pc_q;
              end else if (tape_rdata != 8'd0) begin
                pc_q <= PCW'(stk_rdata) + PCW'(1);
              end else begin
                lvl_q <= lvl_q - LVW'(1);
              end
            end
            default: begin
            end
          endcase
        end
        S_SKIP_RD: begin
          if (skip_a_q < end_w) begin
            state_q <= S_SKIP_CHK;
          end else begin
            pc_q        <= skip_a_q + PCW'(1);
            res_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_SKIP_CHK: begin
          if (prog_rdata == CH_CLOSE && depth_q == '0) begin
            pc_q        <= skip_a_q + PCW'(1);
            res_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            if (prog_rdata == CH_OPEN) begin
              depth_q <= depth_q + PCW'(1);
            end else if (prog_rdata == CH_CLOSE) begin
              depth_q <= depth_q - PCW'(1);
            end
            skip_a_q <= skip_a_q + PCW'(1);
            state_q  <= S_SKIP_RD;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o            = (state_q != S_IDLE);
  assign res_valid_o       = res_valid_q;
  assign res_o.out_valid   = ov_q;
  assign res_o.out_byte    = ob_q;
  assign res_o.in_taken    = tk_q;
  assign res_o.halted      = halted_w;
  assign res_o.status      = err_q;

`ifndef NO_ASSERTIONS
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(lvl_q) <= STACK_DEPTH)
    else $error("loop stack level beyond depth");

  a_error_holds_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != STATUS_OK && state_q != S_CLEAR) |=> $stable(pc_q))
    else $error("program counter moved during error halt");

  a_tape_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tape_we |-> (state_q == S_CLEAR || state_q == S_DECODE))
    else $error("tape written outside clear or decode");
`endif

endmodule

// ----- test/tb_bf_program_executor.sv -----
// Self-checking testbench for bf_program_executor: random and directed program runs.
`timescale 1ns / 1ps

class bf_scoreboard;
  logic [7:0]  tape [1024];
  logic [7:0]  prog [4096];
  int          loops [64];
  int          depth;
  int          pc;
  int          ptr;
  logic [1:0]  err;
  int          prog_len;
  bfpe_pkg::result_t pending [$];
  int          fails;

  function new();
    foreach (tape[i]) tape[i] = 8'd0;
    foreach (prog[i]) prog[i] = 8'd0;
    depth = 0; pc = 0; ptr = 0; err = bfpe_pkg::STATUS_OK; prog_len = 0; fails = 0;
  endfunction

  function void set_length(int v);
    prog_len = v;
  endfunction

  function int prog_end();
    return (prog_len < 4096) ? prog_len : 4096;
  endfunction

  function void step_exec(logic [7:0] in_byte, ref bfpe_pkg::result_t r);
    int          last;
    int          a;
    int          nest;
    logic [7:0]  cur;
    logic [7:0]  op;
    last = prog_end();
    if (err != bfpe_pkg::STATUS_OK || pc >= last) return;
    cur = tape[ptr];
    op = prog[pc];
    case (op)
      bfpe_pkg::CH_RIGHT: if (ptr < 1023) ptr++;
      bfpe_pkg::CH_LEFT:  if (ptr > 0) ptr--;
      bfpe_pkg::CH_INC:   tape[ptr] = cur + 8'd1;
      bfpe_pkg::CH_DEC:   if (cur != 0) tape[ptr] = cur - 8'd1;
      bfpe_pkg::CH_IN: begin
        tape[ptr] = in_byte;
        r.in_taken = 1'b1;
      end
      bfpe_pkg::CH_OUT: begin
        r.out_valid = 1'b1;
        r.out_byte = cur;
      end
      bfpe_pkg::CH_OPEN: begin
        if (cur == 0) begin
          nest = 0;
          a = pc + 1;
          while (a < last) begin
            if (prog[a] == bfpe_pkg::CH_OPEN) nest++;
            else if (prog[a] == bfpe_pkg::CH_CLOSE) begin
              if (nest == 0) break;
              nest--;
            end
            a++;
          end
          pc = a;
        end else if (depth >= 64) begin
          err = bfpe_pkg::STATUS_OVERFLOW;
          return;
        end else begin
          loops[depth] = pc;
          depth++;
        end
      end
      bfpe_pkg::CH_CLOSE: begin
        if (depth == 0) begin
          err = bfpe_pkg::STATUS_UNDERRUN;
          return;
        end
        if (cur != 0) pc = loops[depth-1];
        else depth--;
      end
      default: ;
    endcase
    pc++;
  endfunction

  function void note(bfpe_pkg::item_t it);
    bfpe_pkg::result_t r;
    r = '0;
    case (it.mode)
      bfpe_pkg::MODE_WRITE: prog[it.prog_addr] = it.prog_byte;
      bfpe_pkg::MODE_RESTART: begin
        foreach (tape[i]) tape[i] = 8'd0;
        depth = 0; pc = 0; ptr = 0; err = bfpe_pkg::STATUS_OK;
      end
      bfpe_pkg::MODE_EXEC: step_exec(it.in_byte, r);
      default: ;
    endcase
    r.halted = (err != bfpe_pkg::STATUS_OK) || (pc >= prog_end());
    r.status = err;
    pending.push_back(r);
  endfunction

  function void check(bfpe_pkg::result_t r);
    bfpe_pkg::result_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result beat, actual %p", $time, r);
      fails++;
      return;
    end
    e = pending.pop_front();
    if (r.out_valid !== e.out_valid || r.out_byte !== e.out_byte ||
        r.in_taken !== e.in_taken || r.halted !== e.halted || r.status !== e.status) begin
      $display("%0t: mismatch, expected %p, actual %p", $time, e, r);
      fails++;
    end
  endfunction
endclass

module tb_bf_program_executor;
  import bfpe_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  item_t             item_i = '0;
  logic              res_valid_o;
  result_t           res_o;
  logic              cfg_we_i = 1'b0;
  logic [LEN_W-1:0]  cfg_data_i = '0;

  bf_scoreboard      sb = new();
  bit                quiet = 1'b0;
  int                item_count = 0;

  bf_program_executor DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .item_i(item_i), .res_valid_o(res_valid_o), .res_o(res_o),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) sb.note(item_i);
    if (rst_ni && res_valid_o) sb.check(res_o);
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic send(item_t it);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 38) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy_o);
    item_count++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.pending.size() != 0 || busy_o) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_length(int v);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= LEN_W'(v);
    sb.set_length(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_byte(int a, logic [7:0] b);
    item_t it;
    it = '0;
    it.mode = MODE_WRITE;
    it.prog_addr = 12'(a);
    it.prog_byte = b;
    it.in_byte = 8'($urandom);
    send(it);
  endtask

  task automatic simple(logic [1:0] m, logic [7:0] in_b);
    item_t it;
    it.mode = m;
    it.prog_addr = 12'($urandom);
    it.prog_byte = 8'($urandom);
    it.in_byte = in_b;
    send(it);
  endtask

  task automatic load(logic [7:0] code [$]);
    foreach (code[i]) write_byte(i, code[i]);
  endtask

  task automatic run(int n, bit directed_in);
    repeat (n) simple(MODE_EXEC, directed_in ? 8'hFF : 8'($urandom));
  endtask

  function automatic logic [7:0] pick_op();
    case ($urandom_range(9))
      0: return CH_RIGHT;
      1: return CH_LEFT;
      2: return CH_INC;
      3: return CH_DEC;
      4: return CH_IN;
      5: return CH_OUT;
      6: return CH_OPEN;
      7: return CH_CLOSE;
      8: return CH_INC;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    logic [7:0] code [$];
    int         len;
    int         open_n;
    int         n;
    logic [7:0] c;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    run(1, 1'b1);
    code = '{CH_LEFT, CH_DEC, CH_IN, CH_INC, CH_OUT, CH_OPEN, CH_INC, CH_CLOSE, CH_CLOSE};
    load(code);
    set_length(code.size());
    run(11, 1'b1);
    simple(MODE_UNUSED, 8'h00);
    simple(MODE_RESTART, 8'h00);
    run(3, 1'b1);

    code = '{CH_OPEN, CH_INC};
    load(code);
    set_length(2);
    simple(MODE_RESTART, 8'h00);
    run(2, 1'b1);

    quiet = 1'b1;
    code = '{CH_INC};
    repeat (65) code.push_back(CH_OPEN);
    load(code);
    set_length(code.size());
    simple(MODE_RESTART, 8'h00);
    run(68, 1'b0);
    quiet = 1'b0;

    for (int a = 0; a < 64; a++) begin
      c = (a % 3 == 0) ? CH_DEC : 8'($urandom);
      if (c == CH_OPEN || c == CH_CLOSE) c = CH_RIGHT;
      write_byte(a, c);
    end
    set_length(8191);
    simple(MODE_RESTART, 8'h00);
    run(40, 1'b0);
    set_length(4096);
    simple(MODE_RESTART, 8'h00);
    run(20, 1'b0);

    while (item_count < 900) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 40);
      code.delete();
      open_n = 0;
      for (int i = 0; i < len; i++) begin
        c = pick_op();
        if ($urandom_range(99) < 85) begin
          if (c == CH_CLOSE && open_n == 0) c = CH_INC;
          if (c == CH_OPEN && open_n + 1 > len - i - 1) c = CH_DEC;
          if (open_n > 0 && open_n == len - i) c = CH_CLOSE;
          if (c == CH_OPEN) open_n++;
          if (c == CH_CLOSE) open_n--;
        end
        code.push_back(c);
      end
      load(code);
      set_length(len);
      simple(MODE_RESTART, 8'h00);
      quiet = ($urandom_range(5) == 0);
      n = $urandom_range(10, 60);
      for (int k = 0; k < n; k++) begin
        case ($urandom_range(99))
          0, 1, 2: simple(MODE_UNUSED, 8'($urandom));
          3, 4: write_byte($urandom_range(0, 4095), pick_op());
          5: simple(MODE_RESTART, 8'($urandom));
          6: drain();
          default: simple(MODE_EXEC, 8'($urandom));
        endcase
      end
      quiet = 1'b0;
    end

    drain();
    if (sb.fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
